>>> rtl/lppd_pkg.sv
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types and constants of the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

  localparam int unsigned HDR_CNT_W = 7;
  localparam int unsigned CMDQ_DEPTH = 2;

  localparam logic [4:0] HEADER_LENGTH_RESET = 5'd8;
  localparam logic [15:0] MAX_PACKET_LENGTH_RESET = 16'd29000;

  localparam logic CFG_HEADER_LENGTH = 1'b0;
  localparam logic CFG_MAX_PACKET_LENGTH = 1'b1;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_CLOSE = 1'b1;

  localparam logic [1:0] STATUS_PKT = 2'd0;
  localparam logic [1:0] STATUS_BAD = 2'd1;
  localparam logic [1:0] STATUS_ABORT = 2'd2;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_BAD    = 2'd1,
    CMD_ABORT  = 2'd2,
    CMD_REPLAY = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [7:0]             data;
    logic                   lastp;
    logic [HDR_CNT_W-1:0]   cnt;
    logic                   only;
  } cmd_t;

endpackage

>>> rtl/lppd_ram.sv
// ----------------------------------------------------------------------------
// lppd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lppd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/lppd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lppd_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lppd_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lppd_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output lppd_pkg::cmd_t pop_cmd_o,
  output logic          empty_o
);
  import lppd_pkg::*;

  localparam int unsigned PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          entry_q [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o    = (cnt_q == CW'(CMDQ_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/lppd_front.sv
// ----------------------------------------------------------------------------
// lppd_front
// Accepts input transactions, collects the header, checks its length field
// and issues commands to the back end.
// ----------------------------------------------------------------------------
module lppd_front #(
  parameter int unsigned HEADER_MAX  = 16,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          hdr_wr_en_o,
  output logic [$clog2(HEADER_MAX)-1:0] hdr_wr_addr_o,
  output logic [7:0]                    hdr_wr_data_o,
  output logic                          cmd_push_o,
  output lppd_pkg::cmd_t                cmd_o,
  input  logic                          cmd_full_i,
  input  logic                          replay_done_i
);
  import lppd_pkg::*;

  localparam int unsigned AW        = $clog2(HEADER_MAX);
  localparam int unsigned LEN_BYTES = (LENGTH_BITS + 7) / 8;
  localparam int unsigned HL_LO     = (LEN_BYTES < 2) ? 2 : LEN_BYTES;
  localparam int unsigned LW        = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  logic [4:0]             header_length_q;
  logic [15:0]            max_len_q;
  logic                   phase_q, phase_d;
  logic [HDR_CNT_W-1:0]   count_q, count_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [15:0]            left_q, left_d;
  logic                   busy_q, busy_d;

  logic [HDR_CNT_W-1:0]   hl_raw, hl;
  logic [HDR_CNT_W-1:0]   count_inc;
  logic [LW-1:0]          len_ext, hl_ext, max_ext, diff;
  logic                   accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !cmd_full_i && !(busy_q && !phase_q);

  always_comb begin
    hl_raw = HDR_CNT_W'(header_length_q);
    if (hl_raw < HDR_CNT_W'(HL_LO)) begin
      hl = HDR_CNT_W'(HL_LO);
    end else if (hl_raw > HDR_CNT_W'(HEADER_MAX)) begin
      hl = HDR_CNT_W'(HEADER_MAX);
    end else begin
      hl = hl_raw;
    end
  end

  assign count_inc     = count_q + 1'b1;
  assign hdr_wr_en_o   = accept && (action_i == ACT_BYTE) && !phase_q;
  assign hdr_wr_addr_o = count_q[AW-1:0];
  assign hdr_wr_data_o = data_byte_i;

  assign len_d   = (count_q < HDR_CNT_W'(LEN_BYTES)) ?
                   LENGTH_BITS'({len_q, data_byte_i}) : len_q;
  assign len_ext = LW'(len_d);
  assign hl_ext  = LW'(hl);
  assign max_ext = LW'(max_len_q);
  assign diff    = len_ext - hl_ext;

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    left_d     = left_q;
    busy_d     = busy_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{kind: CMD_BYTE, data: data_byte_i, lastp: 1'b0, cnt: hl,
                   only: 1'b0};
    if (replay_done_i) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      if (action_i == ACT_CLOSE) begin
        if (phase_q || (count_q != '0)) begin
          cmd_push_o = 1'b1;
          cmd_o.kind = CMD_ABORT;
        end
        phase_d = 1'b0;
        count_d = '0;
      end else if (phase_q) begin
        cmd_push_o  = 1'b1;
        cmd_o.kind  = CMD_BYTE;
        cmd_o.lastp = (left_q <= 16'd1);
        if (left_q <= 16'd1) begin
          phase_d = 1'b0;
          count_d = '0;
        end else begin
          left_d = left_q - 16'd1;
        end
      end else if (count_inc >= hl) begin
        cmd_push_o = 1'b1;
        count_d    = '0;
        if ((len_ext < hl_ext) || (len_ext > max_ext)) begin
          cmd_o.kind = CMD_BAD;
        end else begin
          cmd_o.kind = CMD_REPLAY;
          cmd_o.only = (len_ext == hl_ext);
          busy_d     = 1'b1;
          phase_d    = (len_ext != hl_ext);
          left_d     = diff[15:0];
        end
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_length_q <= HEADER_LENGTH_RESET;
      max_len_q       <= MAX_PACKET_LENGTH_RESET;
      phase_q         <= 1'b0;
      count_q         <= '0;
      left_q          <= '0;
      busy_q          <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_HEADER_LENGTH) begin
          header_length_q <= cfg_data_i[4:0];
        end else begin
          max_len_q <= cfg_data_i;
        end
      end
      phase_q <= phase_d;
      count_q <= count_d;
      left_q  <= left_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_wr_en_o) begin
      len_q <= len_d;
    end
  end

endmodule

>>> rtl/lppd_back.sv
// ----------------------------------------------------------------------------
// lppd_back
// Executes queued commands: reports, body bytes and header replays from the
// header store, into the output register.
// ----------------------------------------------------------------------------
module lppd_back #(
  parameter int unsigned HEADER_MAX = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  lppd_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  output logic                          hdr_rd_en_o,
  output logic [$clog2(HEADER_MAX)-1:0] hdr_rd_addr_o,
  input  logic [7:0]                    hdr_rd_data_i,
  output logic                          replay_done_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          first_of_packet_o,
  output logic                          last_of_packet_o,
  output logic [1:0]                    status_o,
  output logic                          last_o
);
  import lppd_pkg::*;

  localparam int unsigned AW = $clog2(HEADER_MAX);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [HDR_CNT_W-1:0] idx_q, idx_d;
  logic [HDR_CNT_W-1:0] cnt_q, cnt_d;
  logic                 only_q, only_d;
  logic                 valid_q, valid_d;
  logic [7:0]           byte_q, byte_d;
  logic                 first_q, first_d;
  logic                 lastp_q, lastp_d;
  logic [1:0]           status_q, status_d;
  logic                 last_q, last_d;
  logic                 load;
  logic                 out_free;
  logic                 fin;

  assign out_free      = !valid_q || out_ready_i;
  assign fin           = ((idx_q + 1'b1) == cnt_q);
  assign hdr_rd_addr_o = idx_q[AW-1:0];

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    only_d        = only_q;
    valid_d       = valid_q && !out_ready_i;
    load          = 1'b0;
    byte_d        = 8'd0;
    first_d       = 1'b0;
    lastp_d       = 1'b0;
    status_d      = STATUS_PKT;
    last_d        = 1'b1;
    cmd_pop_o     = 1'b0;
    hdr_rd_en_o   = 1'b0;
    replay_done_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_REPLAY: begin
              idx_d   = '0;
              cnt_d   = cmd_i.cnt;
              only_d  = cmd_i.only;
              state_d = ST_READ;
            end
            CMD_BYTE: begin
              load    = 1'b1;
              byte_d  = cmd_i.data;
              lastp_d = cmd_i.lastp;
            end
            CMD_BAD: begin
              load     = 1'b1;
              status_d = STATUS_BAD;
            end
            default: begin
              load     = 1'b1;
              status_d = STATUS_ABORT;
            end
          endcase
        end
      end
      ST_READ: begin
        hdr_rd_en_o = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load    = 1'b1;
          byte_d  = hdr_rd_data_i;
          first_d = (idx_q == '0);
          lastp_d = only_q && fin;
          last_d  = fin;
          if (fin) begin
            replay_done_o = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      idx_q   <= '0;
      cnt_q   <= '0;
      only_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      only_q  <= only_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= byte_d;
      first_q  <= first_d;
      lastp_q  <= lastp_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o       = valid_q;
  assign out_byte_o        = byte_q;
  assign first_of_packet_o = first_q;
  assign last_of_packet_o  = lastp_q;
  assign status_o          = status_q;
  assign last_o            = last_q;

endmodule

>>> rtl/length_prefixed_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_core
// Rebuilds length-prefixed packets from a received byte stream.
// ----------------------------------------------------------------------------
// Each input transaction carries one received byte (action 0) or a close
// event (action 1). The header is collected into a small RAM; once complete,
// its leading length field is checked against the header size and the
// configured maximum. A good header is replayed byte by byte with first and
// last packet marks, then each body byte passes through. A bad header gives
// one status 1 result; a close while mid-packet gives one status 2 result.
// The last output marks the final result caused by one input transaction.
// A body byte or a report is queued as a command and then loaded into the
// output register. A header replay is queued by the transaction that
// completes the header and steps through ST_READ and ST_EMIT for each header
// byte, set by the registered read of the header RAM. While a replay is
// pending, a new header byte or a close event
// outside the body waits, since the header RAM is still being read; body
// bytes and close events inside the body queue behind it.
// A stalled receiver holds the output register, then fills the command
// queue, and then deasserts in_ready_o. Reset clears all control state and
// loads the register reset values; there is no clearing pass.
// Configuration writes are accepted in every cycle.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_core #(
  parameter int unsigned HEADER_MAX  = 16,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        first_of_packet_o,
  output logic        last_of_packet_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  import lppd_pkg::*;

  localparam int unsigned AW = $clog2(HEADER_MAX);

  logic          hdr_wr_en;
  logic [AW-1:0] hdr_wr_addr;
  logic [7:0]    hdr_wr_data;
  logic          hdr_rd_en;
  logic [AW-1:0] hdr_rd_addr;
  logic [7:0]    hdr_rd_data;
  logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t          cmd_in, cmd_out;
  logic          replay_done;

  assign cfg_ready_o = 1'b1;

  lppd_front #(
    .HEADER_MAX  (HEADER_MAX),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .hdr_wr_en_o   (hdr_wr_en),
    .hdr_wr_addr_o (hdr_wr_addr),
    .hdr_wr_data_o (hdr_wr_data),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in),
    .cmd_full_i    (cmd_full),
    .replay_done_i (replay_done)
  );

  lppd_ram #(
    .WIDTH (8),
    .DEPTH (HEADER_MAX)
  ) u_hdr_ram (
    .clk_i     (clk_i),
    .wr_en_i   (hdr_wr_en),
    .wr_addr_i (hdr_wr_addr),
    .wr_data_i (hdr_wr_data),
    .rd_en_i   (hdr_rd_en),
    .rd_addr_i (hdr_rd_addr),
    .rd_data_o (hdr_rd_data)
  );

  lppd_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .push_cmd_i (cmd_in),
    .full_o     (cmd_full),
    .pop_i      (cmd_pop),
    .pop_cmd_o  (cmd_out),
    .empty_o    (cmd_empty)
  );

  lppd_back #(
    .HEADER_MAX (HEADER_MAX)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (!cmd_empty),
    .cmd_i             (cmd_out),
    .cmd_pop_o         (cmd_pop),
    .hdr_rd_en_o       (hdr_rd_en),
    .hdr_rd_addr_o     (hdr_rd_addr),
    .hdr_rd_data_i     (hdr_rd_data),
    .replay_done_o     (replay_done),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .first_of_packet_o (first_of_packet_o),
    .last_of_packet_o  (last_of_packet_o),
    .status_o          (status_o),
    .last_o            (last_o)
  );

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("Command pushed into a full queue.");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("Command popped from an empty queue.");

  a_first_is_packet_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && first_of_packet_o) |-> (status_o == STATUS_PKT))
    else $error("First-of-packet mark on a report.");

  a_report_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_PKT)) |->
      ((out_byte_o == 8'd0) && !last_of_packet_o && last_o))
    else $error("Report carries packet data or is not the last result.");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-prefixed packet deframer core.
// ----------------------------------------------------------------------------
// A short table of directed rows comes first: the reset state, register
// extremes, bad headers, header-only packets, aborts, and a header length
// change in the middle of a header. Random packet traffic follows, mostly
// well-formed packets with random content, mixed with bad lengths, cut-off
// packets and noise, under several register settings and three patterns of
// sender and receiver idling. Every result transaction is compared field by
// field with a prediction built from each accepted input transaction.
// ----------------------------------------------------------------------------
module testbench;
  import lppd_pkg::*;

  localparam int HDR_MAX = 16;
  localparam int HDR_AW = $clog2(HDR_MAX);
  localparam int PLAN_AW = $clog2(24);
  localparam int DRAIN_CYCLES = 12;
  localparam int END_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SEGMENT_ITEMS = 34;

  typedef struct packed {
    logic [7:0] data;
    logic       sop;
    logic       eop;
    logic [1:0] status;
    logic       tail;
  } pkt_rec_t;

  typedef struct packed {
    logic        is_cfg;
    logic        cfg_idx;
    logic [15:0] cfg_val;
    logic        act;
    logic [7:0]  b;
    logic        typed;
    logic        has_res;
    pkt_rec_t    res;
  } row_t;

  localparam pkt_rec_t NONE_REC = '0;
  localparam pkt_rec_t BAD_REC = '{8'h00, 1'b0, 1'b0, STATUS_BAD, 1'b1};
  localparam pkt_rec_t ABORT_REC = '{8'h00, 1'b0, 1'b0, STATUS_ABORT, 1'b1};

  localparam row_t DIRECTED_PLAN [24] = '{
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_CLOSE, 8'hFF, 1'b1, 1'b0, NONE_REC},
    '{1'b1, CFG_HEADER_LENGTH, 16'hFFE2, ACT_BYTE, 8'h00, 1'b0, 1'b0, NONE_REC},
    '{1'b1, CFG_MAX_PACKET_LENGTH, 16'h0002, ACT_BYTE, 8'h00, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'h00, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'h02, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'h00, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'h01, 1'b1, 1'b1, BAD_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'h00, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'h03, 1'b1, 1'b1, BAD_REC},
    '{1'b1, CFG_MAX_PACKET_LENGTH, 16'hFFFF, ACT_BYTE, 8'h00, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'hFF, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'hFF, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'h00, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'hFF, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_CLOSE, 8'h00, 1'b1, 1'b1, ABORT_REC},
    '{1'b1, CFG_HEADER_LENGTH, 16'h0001, ACT_BYTE, 8'h00, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'h00, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_CLOSE, 8'hFF, 1'b1, 1'b1, ABORT_REC},
    '{1'b1, CFG_HEADER_LENGTH, 16'h0008, ACT_BYTE, 8'h00, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'h00, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'h04, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'h5A, 1'b0, 1'b0, NONE_REC},
    '{1'b1, CFG_HEADER_LENGTH, 16'h0004, ACT_BYTE, 8'h00, 1'b0, 1'b0, NONE_REC},
    '{1'b0, CFG_HEADER_LENGTH, 16'h0000, ACT_BYTE, 8'hA5, 1'b0, 1'b0, NONE_REC}
  };

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_HEADER_LENGTH;
  logic [15:0] cfg_data_i = 16'h0000;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = ACT_BYTE;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        first_of_packet_o;
  logic        last_of_packet_o;
  logic [1:0]  status_o;
  logic        last_o;

  logic        row_typed = 1'b0;
  logic        row_has_res = 1'b0;
  pkt_rec_t    row_res = '0;

  logic [4:0]  cfg_hdr_len = HEADER_LENGTH_RESET;
  logic [15:0] cfg_max_len = MAX_PACKET_LENGTH_RESET;
  logic        in_body = 1'b0;
  logic [15:0] body_left = 16'h0000;
  logic [7:0]  hdr_mem [HDR_MAX];
  int          hdr_cnt = 0;

  pkt_rec_t    rebuilt_q [$];
  pkt_rec_t    step_q [$];

  int mismatches = 0;
  int quiet_cycles = 0;
  int item_count = 0;
  int send_idle_pct = 28;
  int recv_idle_pct = 88;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;

  length_prefixed_packet_deframer_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .first_of_packet_o(first_of_packet_o),
    .last_of_packet_o (last_of_packet_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_hdr_len(logic [4:0] raw);
    if (raw < 2) return 2;
    if (raw > HDR_MAX) return HDR_MAX;
    return int'(raw);
  endfunction

  function automatic void restart_frame();
    in_body = 1'b0;
    hdr_cnt = 0;
  endfunction

  function automatic void rebuild_step(logic act, logic [7:0] b);
    int hl;
    int i;
    logic [15:0] len;
    logic fin;
    logic only;
    pkt_rec_t rec;
    hl = eff_hdr_len(cfg_hdr_len);
    step_q.delete();
    if (act == ACT_CLOSE) begin
      if (in_body || hdr_cnt > 0) step_q.insert(step_q.size(), ABORT_REC);
      restart_frame();
    end else if (in_body) begin
      fin = (body_left <= 16'd1);
      rec = '{b, 1'b0, fin, STATUS_PKT, 1'b0};
      step_q.insert(step_q.size(), rec);
      if (fin) restart_frame();
      else body_left = body_left - 16'd1;
    end else begin
      if (hdr_cnt < HDR_MAX) hdr_mem[HDR_AW'(hdr_cnt)] = b;
      hdr_cnt++;
      if (hdr_cnt >= hl) begin
        len = {hdr_mem[0], hdr_mem[1]};
        if (int'(len) < hl || len > cfg_max_len) begin
          step_q.insert(step_q.size(), BAD_REC);
          restart_frame();
        end else begin
          only = (int'(len) == hl);
          for (i = 0; i < hl; i++) begin
            rec = '{hdr_mem[HDR_AW'(i)], i == 0, only && (i == hl - 1), STATUS_PKT, 1'b0};
            step_q.insert(step_q.size(), rec);
          end
          if (only) begin
            restart_frame();
          end else begin
            in_body = 1'b1;
            hdr_cnt = 0;
            body_left = len - 16'(hl);
          end
        end
      end
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].tail = 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    pkt_rec_t want;
    if (rebuilt_q.size() == 0) begin
      report_mismatch("result with nothing outstanding", {8'h00, out_byte_o}, 16'h0000);
    end else begin
      want = rebuilt_q.pop_front();
      if (out_byte_o !== want.data)
        report_mismatch("out_byte", 16'(out_byte_o), 16'(want.data));
      if (first_of_packet_o !== want.sop)
        report_mismatch("first_of_packet", 16'(first_of_packet_o), 16'(want.sop));
      if (last_of_packet_o !== want.eop)
        report_mismatch("last_of_packet", 16'(last_of_packet_o), 16'(want.eop));
      if (status_o !== want.status)
        report_mismatch("status", 16'(status_o), 16'(want.status));
      if (last_o !== want.tail) report_mismatch("last", 16'(last_o), 16'(want.tail));
    end
  endtask

  always @(posedge clk) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_HEADER_LENGTH) cfg_hdr_len = cfg_data_i[4:0];
      else cfg_max_len = cfg_data_i;
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      rebuild_step(action_i, data_byte_i);
      if (row_typed) begin
        if (row_has_res) rebuilt_q.insert(rebuilt_q.size(), row_res);
      end else begin
        foreach (step_q[i]) rebuilt_q.insert(rebuilt_q.size(), step_q[i]);
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) check_result();
    if (rst_ni && ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
                   (out_valid_o && out_ready_i)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  always @(negedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(logic act, logic [7:0] b, logic typed = 1'b0,
                           logic has_res = 1'b0, pkt_rec_t res = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    data_byte_i <= b;
    row_typed <= typed;
    row_has_res <= has_res;
    row_res <= res;
    do @(posedge clk); while (!in_ready_o);
    @(negedge clk);
    item_count++;
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    in_valid_i <= 1'b0;
    while (rebuilt_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk); while (!cfg_ready_o);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_packet(int hl, int maxlen);
    int r;
    int len;
    int span;
    int cut;
    int i;
    logic [7:0] fill;
    bit bad;
    bit chopped;
    r = $urandom_range(99);
    if (r < 8) begin
      if (r < 3) send_item(ACT_CLOSE, 8'($urandom));
      else send_item(ACT_BYTE, 8'($urandom));
      return;
    end
    bad = (r < 20) || (maxlen < hl);
    chopped = !bad && (r < 32);
    if (bad) begin
      if (maxlen < 65535 && $urandom_range(1) == 1) begin
        len = maxlen + 1 + $urandom_range(0, 3);
        if (len > 65535) len = 65535;
      end else begin
        len = $urandom_range(0, hl - 1);
      end
      cut = hl;
    end else begin
      span = maxlen - hl;
      if (span > 20) span = 20;
      len = hl + $urandom_range(0, span);
      cut = chopped ? $urandom_range(0, len - 1) : len;
    end
    for (i = 0; i < cut; i++) begin
      if (i == 0) fill = 8'(len >> 8);
      else if (i == 1) fill = 8'(len);
      else fill = 8'($urandom);
      send_item(ACT_BYTE, fill);
    end
    if (chopped) send_item(ACT_CLOSE, 8'($urandom));
  endtask

  initial begin
    int i;
    int ph;
    int seg;
    int k;
    int target;
    logic [4:0] hl_raw;
    logic [15:0] max_v;
    row_t row;
    repeat (12) @(negedge clk);
    rst_ni <= 1'b1;

    for (i = 0; i < $size(DIRECTED_PLAN); i++) begin
      row = DIRECTED_PLAN[PLAN_AW'(i)];
      if (row.is_cfg)
        write_reg(row.cfg_idx, row.cfg_val);
      else
        send_item(row.act, row.b, row.typed, row.has_res, row.res);
    end

    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 88 : 0;
      recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 28 : 0;
      for (seg = 0; seg < 4; seg++) begin
        k = ph * 4 + seg;
        case (k)
          0: begin hl_raw = 5'd8; max_v = 16'd60; end
          1: begin hl_raw = 5'd2; max_v = 16'd2; end
          2: begin hl_raw = 5'd31; max_v = 16'hFFFF; end
          5: begin hl_raw = 5'd16; max_v = 16'd36; end
          7: begin hl_raw = 5'd0; max_v = 16'd3; end
          10: begin hl_raw = 5'd17; max_v = 16'd2; end
          default: begin
            hl_raw = 5'($urandom_range(0, 31));
            max_v = 16'(eff_hdr_len(hl_raw) + $urandom_range(0, 40));
          end
        endcase
        write_reg(CFG_HEADER_LENGTH, {11'($urandom), hl_raw});
        write_reg(CFG_MAX_PACKET_LENGTH, max_v);
        // The receiver stops for a long stretch while the sender keeps going.
        if (k == 8) hold_asked++;
        target = item_count + SEGMENT_ITEMS;
        while (item_count < target) send_packet(eff_hdr_len(hl_raw), int'(max_v));
      end
    end

    in_valid_i <= 1'b0;
    while (rebuilt_q.size() != 0) @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
